/* sv/sem_pkg.sv */
// Shared types, constants and command structures for the Sobel edge magnitude block.
`default_nettype none

package sem_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int PIX_W         = 8;
	localparam int WIDTH_REG_W   = 11;
	localparam int HEIGHT_REG_W  = 12;
	localparam int RESET_WIDTH   = 640;
	localparam int RESET_HEIGHT  = 480;
	// Rows run up to the configured height plus one while the last row drains.
	localparam int ROW_W         = HEIGHT_REG_W + 1;
	localparam int GRAD_W        = 11;
	localparam int SUMSQ_W       = 21;
	localparam int RAD_W         = 16;
	localparam int SQRT_STEPS    = 8;
	localparam int STEP_W        = 3;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [PIX_W-1:0] MAG_CLAMP = 8'd255;

	// Register index codes, taken from paddr[2].
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_SQUARE,
		S_SQRT,
		S_DONE
	} sem_state_t;

	typedef struct packed {
		logic              load;
		logic              update;
		logic              square;
		logic              sqrt_step;
		logic [STEP_W-1:0] step;
		logic              out_load;
	} sem_cmd_t;

	typedef struct packed {
		logic emit;
	} sem_stat_t;

endpackage

`default_nettype wire

/* sv/sobel_edge_magnitude.sv */
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Pixels enter in raster order on the pixel channel (pixel_valid/pixel_stall, fields pixel
// and drain); clamped magnitudes leave on the result channel (result_valid/result_stall,
// fields magnitude and frame_end). A result belongs to the position width+1 beats back, so
// after a frame's last pixel the host sends width+1 drain beats; frame_end marks the last.
// Width and height are set through the APB port (0x0 width, 0x4 height); a write restarts
// the frame and is meant to be issued only while the block is idle.
// Sequence: a beat with no result (the first row and the first beat of the second) passes
// the line store read and the update, then returns to idle. A beat with a result goes on
// through squaring, eight steps of the restoring square-root unit at one root bit per
// cycle, and the output load. The next beat is taken while that result still waits in the
// output register; a stalled receiver holds the block only when a second result is ready.
// Reset sets width 640 and height 480, clears the window and counters and empties the output.
// The line store is not cleared; entries are written before they reach a result.
`default_nettype none

module sobel_edge_magnitude #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [sem_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [sem_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [sem_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	input  wire logic                            pixel_valid,
	output logic                                 pixel_stall,
	input  wire logic [sem_pkg::PIX_W-1:0]       pixel,
	input  wire logic                            drain,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic      [sem_pkg::PIX_W-1:0]       magnitude,
	output logic                                 frame_end
);

	logic [sem_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [sem_pkg::HEIGHT_REG_W-1:0] height_q;
	logic cfg_wr;
	logic reg_sel;

	sem_pkg::sem_cmd_t  cmd;
	sem_pkg::sem_stat_t stat;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::WIDTH_REG_W'(sem_pkg::RESET_WIDTH);
			height_q <= sem_pkg::HEIGHT_REG_W'(sem_pkg::RESET_HEIGHT);
		end else if (cfg_wr) begin
			case (reg_sel)
				sem_pkg::REG_WIDTH:  width_q  <= pwdata[sem_pkg::WIDTH_REG_W-1:0];
				sem_pkg::REG_HEIGHT: height_q <= pwdata[sem_pkg::HEIGHT_REG_W-1:0];
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			sem_pkg::REG_WIDTH:  prdata = sem_pkg::APB_DATA_W'(width_q);
			sem_pkg::REG_HEIGHT: prdata = sem_pkg::APB_DATA_W'(height_q);
			default:             prdata = '0;
		endcase
	end

	sem_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	sem_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_restart (cfg_wr),
		.width_cfg   (width_q),
		.height_cfg  (height_q),
		.pixel       (pixel),
		.drain       (drain),
		.stat        (stat),
		.magnitude   (magnitude),
		.frame_end   (frame_end)
	);

endmodule

`default_nettype wire

/* sv/sem_ctrl.sv */
// Sequencing state machine for the Sobel edge magnitude block.
`default_nettype none

module sem_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pixel_valid,
	output logic                     pixel_stall,
	output logic                     result_valid,
	input  wire logic                result_stall,
	input  wire sem_pkg::sem_stat_t  stat,
	output sem_pkg::sem_cmd_t        cmd
);

	sem_pkg::sem_state_t state_q, state_d;
	logic [sem_pkg::STEP_W-1:0] step_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sem_pkg::S_IDLE: begin
				if (pixel_valid) state_d = sem_pkg::S_UPDATE;
			end
			sem_pkg::S_UPDATE: begin
				state_d = stat.emit ? sem_pkg::S_SQUARE : sem_pkg::S_IDLE;
			end
			sem_pkg::S_SQUARE: begin
				state_d = sem_pkg::S_SQRT;
			end
			sem_pkg::S_SQRT: begin
				if (step_q == '0) state_d = sem_pkg::S_DONE;
			end
			sem_pkg::S_DONE: begin
				if (out_free) state_d = sem_pkg::S_IDLE;
			end
			default: begin
				state_d = sem_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.step      = step_q;
		pixel_stall   = 1'b1;
		case (state_q)
			sem_pkg::S_IDLE: begin
				pixel_stall = 1'b0;
				cmd.load    = pixel_valid;
			end
			sem_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
			end
			sem_pkg::S_SQUARE: begin
				cmd.square = 1'b1;
			end
			sem_pkg::S_SQRT: begin
				cmd.sqrt_step = 1'b1;
			end
			sem_pkg::S_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				pixel_stall = 1'b1;
			end
		endcase
	end

	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sem_pkg::S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.square) begin
				step_q <= sem_pkg::STEP_W'(sem_pkg::SQRT_STEPS - 1);
			end else if (cmd.sqrt_step) begin
				step_q <= step_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_sqrt_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sem_pkg::S_SQRT && step_q == '0) |=> state_q == sem_pkg::S_DONE)
		else $error("square root did not finish after its last step");

	a_no_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sem_pkg::S_UPDATE && !stat.emit) |=> state_q == sem_pkg::S_IDLE)
		else $error("item without a result did not return to idle");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sem_pkg::S_DONE && out_valid_q && result_stall)
		|=> (state_q == sem_pkg::S_DONE && out_valid_q))
		else $error("finished result overwrote a stalled output beat");

endmodule

`default_nettype wire

/* sv/sem_datapath.sv */
// Line store, window, gradient, square and square-root datapath of the Sobel block.
`default_nettype none

module sem_datapath #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sem_pkg::sem_cmd_t                 cmd,
	input  wire logic                              cfg_restart,
	input  wire logic [sem_pkg::WIDTH_REG_W-1:0]   width_cfg,
	input  wire logic [sem_pkg::HEIGHT_REG_W-1:0]  height_cfg,
	input  wire logic [sem_pkg::PIX_W-1:0]         pixel,
	input  wire logic                              drain,
	output sem_pkg::sem_stat_t                     stat,
	output logic [sem_pkg::PIX_W-1:0]              magnitude,
	output logic                                   frame_end
);

	localparam int PW    = sem_pkg::PIX_W;
	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EFF_W = $clog2(MAX_WIDTH + 1);
	localparam int CW    = (EFF_W > sem_pkg::WIDTH_REG_W) ? EFF_W : sem_pkg::WIDTH_REG_W;
	localparam int RW    = sem_pkg::ROW_W;
	localparam int GW    = sem_pkg::GRAD_W;
	localparam int SW    = GW - 1;
	localparam int RAD   = sem_pkg::RAD_W;
	localparam int SQW   = sem_pkg::SUMSQ_W;

	logic [2*PW-1:0] line_mem [MAX_WIDTH];
	logic [2*PW-1:0] rd_q;
	logic [PW-1:0]   pix_q;
	logic            drain_q;

	logic [PW-1:0]    win_q [3][3];
	logic [COL_W-1:0] col_q;
	logic [RW-1:0]    row_q;

	logic signed [GW-1:0] gx_q, gy_q;
	logic                 fend_q;
	logic [RAD-1:0]       v_q, root_q;
	logic                 big_q;
	logic [PW-1:0]        mag_q;
	logic                 mag_fend_q;

	// Effective frame size.
	logic [CW-1:0] width_ext, w_eff, col_ext, col_inc, ocol;
	logic [RW-1:0] h_eff, orow;

	always_comb begin
		width_ext = CW'(width_cfg);
		if (width_cfg == '0) begin
			w_eff = CW'(1);
		end else if (width_ext > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = width_ext;
		end
		h_eff = (height_cfg == '0) ? RW'(1) : RW'(height_cfg);
	end

	// New window column from the line store and the incoming beat.
	logic [PW-1:0] top, mid, bot;
	logic          emit_right, emit_inner, emit, fend_d;

	always_comb begin
		mid = rd_q[PW-1:0];
		top = (row_q <= RW'(1)) ? mid : rd_q[2*PW-1:PW];
		if (row_q < h_eff) begin
			bot = drain_q ? '0 : pix_q;
		end else begin
			bot = mid;
		end
	end

	assign col_ext = CW'(col_q);
	assign col_inc = col_ext + CW'(1);

	// The first column of a row closes the right-edge position of the row two above.
	assign emit_right = (col_q == '0) && (row_q >= RW'(2));
	assign emit_inner = (col_q != '0) && (row_q >= RW'(1));
	assign emit       = emit_right || emit_inner;
	assign orow       = emit_right ? row_q - RW'(2) : row_q - RW'(1);
	assign ocol       = emit_right ? w_eff - CW'(1) : col_ext - CW'(1);
	assign fend_d     = emit && (orow == h_eff - RW'(1)) && (ocol == w_eff - CW'(1));

	assign stat.emit = emit;

	// Left, centre and right columns of the neighbourhood, edges replicated.
	logic [PW-1:0] lv [3];
	logic [PW-1:0] cv [3];
	logic [PW-1:0] rv [3];
	logic [PW-1:0] newc [3];

	always_comb begin
		newc[0] = top;
		newc[1] = mid;
		newc[2] = bot;
		for (int r = 0; r < 3; r++) begin
			cv[r] = win_q[r][2];
			if (emit_right) begin
				lv[r] = (w_eff == CW'(1)) ? win_q[r][2] : win_q[r][1];
				rv[r] = win_q[r][2];
			end else begin
				lv[r] = (col_q == COL_W'(1)) ? win_q[r][2] : win_q[r][1];
				rv[r] = newc[r];
			end
		end
	end

	logic [SW-1:0] sum_l, sum_r, sum_t, sum_b;
	logic signed [GW-1:0] gx_d, gy_d;

	always_comb begin
		sum_l = SW'(lv[0]) + {1'b0, lv[1], 1'b0} + SW'(lv[2]);
		sum_r = SW'(rv[0]) + {1'b0, rv[1], 1'b0} + SW'(rv[2]);
		sum_t = SW'(lv[0]) + {1'b0, cv[0], 1'b0} + SW'(rv[0]);
		sum_b = SW'(lv[2]) + {1'b0, cv[2], 1'b0} + SW'(rv[2]);
		gx_d  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy_d  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
	end

	// Squares of the gradients.
	logic signed [2*GW-1:0] sqx, sqy;
	logic [SQW-1:0] sumsq;

	assign sqx   = gx_q * gx_q;
	assign sqy   = gy_q * gy_q;
	assign sumsq = SQW'(sqx[SQW-2:0]) + SQW'(sqy[SQW-2:0]);

	// One restoring square-root step: the trial bit falls by two places each cycle.
	logic [RAD-1:0] bit_v;
	logic [RAD:0]   trial;
	logic           fits;

	assign bit_v = RAD'(1) << {cmd.step, 1'b0};
	assign trial = {1'b0, root_q} + {1'b0, bit_v};
	assign fits  = {1'b0, v_q} >= trial;

	// Line store: read when a beat is taken, written back in the update cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= line_mem[col_q];
		end
		if (cmd.update) begin
			line_mem[col_q] <= {mid, bot};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q   <= pixel;
			drain_q <= drain;
		end
		if (cmd.update) begin
			gx_q   <= gx_d;
			gy_q   <= gy_d;
			fend_q <= fend_d;
		end
		if (cmd.square) begin
			v_q    <= sumsq[RAD-1:0];
			big_q  <= |sumsq[SQW-1:RAD];
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			if (fits) begin
				v_q    <= v_q - trial[RAD-1:0];
				root_q <= (root_q >> 1) + bit_v;
			end else begin
				root_q <= root_q >> 1;
			end
		end
		if (cmd.out_load) begin
			mag_q      <= big_q ? sem_pkg::MAG_CLAMP : root_q[PW-1:0];
			mag_fend_q <= fend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (cfg_restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.update) begin
				if (fend_d) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end
			if (cmd.update) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
					win_q[r][2] <= newc[r];
				end
			end
		end
	end

	assign magnitude = mag_q;
	assign frame_end = mag_fend_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < w_eff)
		else $error("column counter ran past the row width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_eff + RW'(1))
		else $error("row counter ran past the drain row");

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !big_q) |-> root_q[RAD-1:PW] == '0)
		else $error("square root grew past the magnitude width");

endmodule

`default_nettype wire

/* tb/sobel_edge_magnitude_tb.sv */
// Self-checking testbench for the streaming Sobel edge magnitude block.
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

	localparam int unsigned SETTLE_CYCLES  = 24;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned RANDOM_ITEMS   = 420;

	typedef enum int unsigned {
		FILL_RANDOM,
		FILL_WHITE,
		FILL_STEP,
		FILL_EXTREMES
	} fill_t;

	typedef struct packed {
		logic [sem_pkg::PIX_W-1:0] magnitude;
		logic                      frame_end;
	} edge_result_t;

	// Tracks the window and line rows as pixels go in and holds the magnitudes still owed.
	class sobel_window_tracker;
		logic [sem_pkg::WIDTH_REG_W-1:0]  width_reg;
		logic [sem_pkg::HEIGHT_REG_W-1:0] height_reg;
		logic [15:0]                      line_rows [sem_pkg::MAX_WIDTH];
		logic [7:0]                       win [3][3];
		int unsigned                      in_col;
		int unsigned                      in_row;
		edge_result_t                     awaited_magnitudes [$];
		int unsigned                      errors;

		function new();
			width_reg  = sem_pkg::RESET_WIDTH;
			height_reg = sem_pkg::RESET_HEIGHT;
			foreach (line_rows[i])
				line_rows[i] = '0;
			foreach (win[r, c])
				win[r][c] = '0;
			in_col = 0;
			in_row = 0;
			errors = 0;
		endfunction

		function int unsigned frame_cols();
			if (width_reg == 0)
				return 1;
			if (width_reg > sem_pkg::MAX_WIDTH)
				return sem_pkg::MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned frame_rows();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function int unsigned awaited();
			return awaited_magnitudes.size();
		endfunction

		// A register write restarts the frame; the line rows and the window are kept.
		function void write_register(logic idx, logic [31:0] value);
			if (idx == sem_pkg::REG_WIDTH)
				width_reg = value[sem_pkg::WIDTH_REG_W-1:0];
			else
				height_reg = value[sem_pkg::HEIGHT_REG_W-1:0];
			in_col = 0;
			in_row = 0;
		endfunction

		function int at(int r, int c);
			return int'(win[r][c]);
		endfunction

		function logic [7:0] grad_mag(int lc, int cc, int rc);
			int gx, gy, sum_sq, root;
			gx = (at(0, rc) + 2 * at(1, rc) + at(2, rc)) - (at(0, lc) + 2 * at(1, lc) + at(2, lc));
			gy = (at(2, lc) + 2 * at(2, cc) + at(2, rc)) - (at(0, lc) + 2 * at(0, cc) + at(0, rc));
			sum_sq = gx * gx + gy * gy;
			if (sum_sq >= 65536)
				return sem_pkg::MAG_CLAMP;
			root = 0;
			while ((root + 1) * (root + 1) <= sum_sq)
				root++;
			return 8'(root);
		endfunction

		function void note_pixel(logic [7:0] px, logic dr);
			int unsigned  w, h, ic, ir, orow, ocol;
			logic [7:0]   top, mid, bot;
			bit           emit;
			edge_result_t res;
			w    = frame_cols();
			h    = frame_rows();
			ic   = in_col;
			ir   = in_row;
			emit = 1'b0;
			res  = '0;
			orow = 0;
			ocol = 0;
			mid  = line_rows[ic][7:0];
			top  = line_rows[ic][15:8];
			// The first two rows see the top edge replicated.
			if (ir <= 1)
				top = mid;
			// Below the last row the bottom edge is replicated, whatever the beat carries.
			if (ir < h)
				bot = dr ? 8'h00 : px;
			else
				bot = mid;
			line_rows[ic] = {mid, bot};
			// A new row starting finishes the right-hand pixel of the row two above.
			if (ic == 0 && ir >= 2) begin
				res.magnitude = grad_mag((w == 1) ? 2 : 1, 2, 2);
				orow = ir - 2;
				ocol = w - 1;
				emit = 1'b1;
			end
			for (int r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = bot;
			if (ic != 0 && ir >= 1) begin
				res.magnitude = grad_mag((ic == 1) ? 1 : 0, 1, 2);
				orow = ir - 1;
				ocol = ic - 1;
				emit = 1'b1;
			end
			if (emit) begin
				res.frame_end = (orow == h - 1) && (ocol == w - 1);
				awaited_magnitudes.push_back(res);
			end
			if (emit && res.frame_end) begin
				in_col = 0;
				in_row = 0;
			end else begin
				ic++;
				if (ic >= w) begin
					ic = 0;
					ir++;
				end
				in_col = ic;
				in_row = ir;
			end
		endfunction

		function void check_magnitude(logic [7:0] mag, logic fe);
			edge_result_t exp_res;
			if (awaited_magnitudes.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: magnitude %0d frame_end %0b",
					$time, mag, fe);
				return;
			end
			exp_res = awaited_magnitudes.pop_front();
			if (mag !== exp_res.magnitude) begin
				errors++;
				$display("%0t: magnitude expected %0d, actual %0d",
					$time, exp_res.magnitude, mag);
			end
			if (fe !== exp_res.frame_end) begin
				errors++;
				$display("%0t: frame_end expected %0b, actual %0b",
					$time, exp_res.frame_end, fe);
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [sem_pkg::APB_ADDR_W-1:0]   paddr = '0;
	logic [sem_pkg::APB_DATA_W-1:0]   pwdata = '0;
	logic [sem_pkg::APB_DATA_W-1:0]   prdata;
	logic                             pready;
	logic                             pixel_valid = 1'b0;
	logic                             pixel_stall;
	logic [sem_pkg::PIX_W-1:0]        pixel = '0;
	logic                             drain = 1'b0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	logic [sem_pkg::PIX_W-1:0]        magnitude;
	logic                             frame_end;

	sobel_window_tracker tracker;
	int unsigned         stall_pct = 0;
	int unsigned         stall_left = 0;
	bit                  sender_gaps = 1'b0;
	int unsigned         burst_left = 0;
	int unsigned         items_sent = 0;
	int unsigned         quiet_cycles = 0;

	wire pixel_beat  = pixel_valid && !pixel_stall;
	wire result_beat = result_valid && !result_stall;

	sobel_edge_magnitude dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.drain        (drain),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.magnitude    (magnitude),
		.frame_end    (frame_end)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_beat)
				tracker.check_magnitude(magnitude, frame_end);
			if (pixel_beat)
				tracker.note_pixel(pixel, drain);
		end
	end

	// Receiver stalls come in runs at a rate set per phase.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(1, 100) <= stall_pct) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 5);
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (pixel_beat || result_beat) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_register(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		tracker.write_register(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_beat(input logic [7:0] px, input logic dr);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (sender_gaps) begin
				gap = $urandom_range(0, 8);
				if (gap != 0) begin
					pixel_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		pixel_valid <= 1'b1;
		pixel       <= px;
		drain       <= dr;
		do
			@(posedge clk);
		while (pixel_stall);
		items_sent++;
	endtask

	function automatic logic [7:0] pick_pixel(fill_t fill, int unsigned col, int unsigned w);
		case (fill)
			FILL_WHITE:    return 8'hFF;
			FILL_STEP:     return (2 * col >= w) ? 8'hFF : 8'h00;
			FILL_EXTREMES: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:       return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One whole frame, then the width+1 trailing beats that flush it out.
	task automatic send_frame(input fill_t fill, input int unsigned hole_pct);
		int unsigned w, h;
		w = tracker.frame_cols();
		h = tracker.frame_rows();
		for (int unsigned r = 0; r < h; r++)
			for (int unsigned c = 0; c < w; c++)
				send_beat(pick_pixel(fill, c, w), $urandom_range(1, 100) <= hole_pct);
		for (int unsigned i = 0; i <= w; i++)
			send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
	endtask

	task automatic send_loose(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
	endtask

	// The pause lets a beat that owes no result finish before the next register write.
	task automatic wait_quiet();
		pixel_valid <= 1'b0;
		while (tracker.awaited() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned cols, rows, frames, loop_start, sel;
		bit          first;
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// A few beats under the reset geometry, then a one by one frame from zero registers.
		stall_pct   = 30;
		sender_gaps = 1'b1;
		send_loose(6);
		wait_quiet();
		write_register(sem_pkg::REG_WIDTH, 32'd0);
		write_register(sem_pkg::REG_HEIGHT, 32'd0);
		send_frame(FILL_WHITE, 0);
		wait_quiet();

		// A hard vertical step saturates the magnitude.
		write_register(sem_pkg::REG_WIDTH, 32'd3);
		write_register(sem_pkg::REG_HEIGHT, 32'd3);
		send_frame(FILL_STEP, 0);
		wait_quiet();

		// Drain inside the frame reads as black; a pixel below the last row is ignored.
		write_register(sem_pkg::REG_WIDTH, 32'd2);
		write_register(sem_pkg::REG_HEIGHT, 32'd1);
		send_beat(8'hFF, 1'b1);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h5A, 1'b0);
		send_beat(8'h00, 1'b1);
		send_beat(8'hC3, 1'b0);
		wait_quiet();

		// Oversized width clamps to the line store depth; the short row is cut by the next write.
		stall_pct   = 10;
		sender_gaps = 1'b0;
		write_register(sem_pkg::REG_WIDTH, 32'd2047);
		write_register(sem_pkg::REG_HEIGHT, 32'd1);
		send_loose(12);
		wait_quiet();

		// Tallest frame, left unfinished; the next write restarts it.
		write_register(sem_pkg::REG_WIDTH, 32'd2);
		write_register(sem_pkg::REG_HEIGHT, 32'd4095);
		send_loose(40);
		wait_quiet();

		first      = 1'b1;
		loop_start = items_sent;
		while (items_sent - loop_start < RANDOM_ITEMS) begin
			cols = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			rows = $urandom_range(1, 8);
			sel  = first ? 2 : $urandom_range(0, 3);
			first = 1'b0;
			case (sel)
				0: write_register(sem_pkg::REG_WIDTH, ($urandom & 32'hFFFF_F800) | cols);
				1: write_register(sem_pkg::REG_HEIGHT, ($urandom & 32'hFFFF_F000) | rows);
				default: begin
					if ($urandom_range(0, 1)) begin
						write_register(sem_pkg::REG_WIDTH, ($urandom & 32'hFFFF_F800) | cols);
						write_register(sem_pkg::REG_HEIGHT, ($urandom & 32'hFFFF_F000) | rows);
					end else begin
						write_register(sem_pkg::REG_HEIGHT, ($urandom & 32'hFFFF_F000) | rows);
						write_register(sem_pkg::REG_WIDTH, ($urandom & 32'hFFFF_F800) | cols);
					end
				end
			endcase
			case ($urandom_range(0, 2))
				0:       stall_pct = 0;
				1:       stall_pct = 25;
				default: stall_pct = 60;
			endcase
			sender_gaps = $urandom_range(0, 1);
			frames = $urandom_range(1, 3);
			for (int unsigned f = 0; f < frames; f++)
				send_frame(fill_t'($urandom_range(0, 3)), $urandom_range(0, 1) ? 0 : 10);
			// Now and then a frame is cut short and the next write restarts it.
			if ($urandom_range(0, 5) == 0)
				send_loose($urandom_range(1, tracker.frame_cols() * tracker.frame_rows()));
			wait_quiet();
		end

		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/sem_pkg.sv
sv/sem_ctrl.sv
sv/sem_datapath.sv
sv/sobel_edge_magnitude.sv
tb/sobel_edge_magnitude_tb.sv
